FILE: sv/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, constants, the microcode table and the address wrap helper
// for the animation track sampler.
// ----------------------------------------------------------------------------
package ats_pkg;

   localparam int TRACK_WORDS_DEF = 4096;
   localparam int FRAME_BITS_DEF  = 10;

   localparam int LOAD_ADDR_W = 12;
   localparam int WORD_W      = 16;
   localparam int FRAME_W     = 10;
   localparam int FRAC_W      = 16;
   localparam int VALUE_W     = 32;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Microprogram step addresses.
   typedef enum logic [3:0] {
      STEP_IDLE   = 4'd0,
      STEP_RD_HDR = 4'd1,
      STEP_HDR    = 4'd2,
      STEP_TEST   = 4'd3,
      STEP_ADV    = 4'd4,
      STEP_PICK   = 4'd5,
      STEP_RD_A   = 4'd6,
      STEP_RD_B   = 4'd7,
      STEP_LAT_B  = 4'd8,
      STEP_MUL_F  = 4'd9,
      STEP_MAKE_V = 4'd10,
      STEP_MUL_LO = 4'd11,
      STEP_MUL_HI = 4'd12,
      STEP_ACC_HI = 4'd13,
      STEP_SUM    = 4'd14,
      STEP_EMIT   = 4'd15
   } step_type;

   // Datapath operations selected by a control word.
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_RD_HDR,
      OP_HDR,
      OP_TEST,
      OP_ADV,
      OP_PICK,
      OP_RD_A,
      OP_RD_B,
      OP_LAT_B,
      OP_MUL_F,
      OP_MAKE_V,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_ACC_HI,
      OP_SUM,
      OP_EMIT
   } op_type;

   // Sequencing conditions.
   typedef enum logic [2:0] {
      CND_SEQ,
      CND_GOTO,
      CND_IDLE,
      CND_WALK,
      CND_EMIT
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   // Sequencer to datapath.
   typedef struct packed {
      logic   idle;
      op_type op;
   } seq_ctrl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic start;
      logic with_track;
      logic walk;
      logic out_free;
   } dp_stat_type;

   function automatic uword_type ucode(input step_type pc);
      uword_type w;
      case (pc)
         STEP_IDLE:   w = '{OP_IDLE,   CND_IDLE, STEP_SUM};
         STEP_RD_HDR: w = '{OP_RD_HDR, CND_SEQ,  STEP_IDLE};
         STEP_HDR:    w = '{OP_HDR,    CND_SEQ,  STEP_IDLE};
         STEP_TEST:   w = '{OP_TEST,   CND_WALK, STEP_PICK};
         STEP_ADV:    w = '{OP_ADV,    CND_GOTO, STEP_RD_HDR};
         STEP_PICK:   w = '{OP_PICK,   CND_SEQ,  STEP_IDLE};
         STEP_RD_A:   w = '{OP_RD_A,   CND_SEQ,  STEP_IDLE};
         STEP_RD_B:   w = '{OP_RD_B,   CND_SEQ,  STEP_IDLE};
         STEP_LAT_B:  w = '{OP_LAT_B,  CND_SEQ,  STEP_IDLE};
         STEP_MUL_F:  w = '{OP_MUL_F,  CND_SEQ,  STEP_IDLE};
         STEP_MAKE_V: w = '{OP_MAKE_V, CND_SEQ,  STEP_IDLE};
         STEP_MUL_LO: w = '{OP_MUL_LO, CND_SEQ,  STEP_IDLE};
         STEP_MUL_HI: w = '{OP_MUL_HI, CND_SEQ,  STEP_IDLE};
         STEP_ACC_HI: w = '{OP_ACC_HI, CND_SEQ,  STEP_IDLE};
         STEP_SUM:    w = '{OP_SUM,    CND_SEQ,  STEP_IDLE};
         STEP_EMIT:   w = '{OP_EMIT,   CND_EMIT, STEP_IDLE};
         default:     w = '{OP_IDLE,   CND_GOTO, STEP_IDLE};
      endcase
      return w;
   endfunction

   // Reduces x modulo tw for any x below sixteen times tw.
   function automatic logic [19:0] wrap_addr(input logic [19:0] x, input logic [19:0] tw);
      logic [19:0] r;
      r = x;
      for (int i = 3; i >= 0; i--) begin
         if (r >= (tw << i)) begin
            r = r - (tw << i);
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/ats_seq.sv
// ----------------------------------------------------------------------------
// ats_seq
// Microcode sequencer: step counter, control word lookup and jumps.
// ----------------------------------------------------------------------------
module ats_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  ats_pkg::dp_stat_type stat,
   output ats_pkg::seq_ctrl_type ctrl
);

   ats_pkg::step_type  pc_ff;
   ats_pkg::step_type  pc_in;
   ats_pkg::uword_type uw;
   ats_pkg::step_type  pc_next_seq;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ats_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      uw          = ats_pkg::ucode(pc_ff);
      pc_next_seq = ats_pkg::step_type'(pc_ff + 4'd1);
      case (uw.cond)
         ats_pkg::CND_SEQ:  pc_in = pc_next_seq;
         ats_pkg::CND_GOTO: pc_in = uw.target;
         ats_pkg::CND_IDLE: begin
            if (stat.start) begin
               pc_in = stat.with_track ? pc_next_seq : uw.target;
            end else begin
               pc_in = pc_ff;
            end
         end
         ats_pkg::CND_WALK: pc_in = stat.walk ? pc_next_seq : uw.target;
         ats_pkg::CND_EMIT: pc_in = stat.out_free ? uw.target : pc_ff;
         default:           pc_in = ats_pkg::STEP_IDLE;
      endcase
      ctrl.idle = (pc_ff == ats_pkg::STEP_IDLE);
      ctrl.op   = uw.op;
   end

endmodule

FILE: sv/ats_datapath.sv
// ----------------------------------------------------------------------------
// ats_datapath
// Track memory, span walk registers, shared multiplier, accumulator and the
// result register, all steered by the sequencer's control word.
// ----------------------------------------------------------------------------
module ats_datapath #(
   parameter int TRACK_WORDS = ats_pkg::TRACK_WORDS_DEF,
   parameter int FRAME_BITS  = ats_pkg::FRAME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ats_pkg::seq_ctrl_type             ctrl,
   output ats_pkg::dp_stat_type              stat,
   input  logic                              req_valid,
   input  logic                              req_func,
   input  logic [ats_pkg::LOAD_ADDR_W-1:0]   req_load_addr,
   input  logic [ats_pkg::WORD_W-1:0]        req_load_word,
   input  logic                              req_has_track,
   input  logic [ats_pkg::LOAD_ADDR_W-1:0]   req_track_start,
   input  logic [ats_pkg::FRAME_W-1:0]       req_frame,
   input  logic [ats_pkg::FRAC_W-1:0]        req_frac,
   input  logic signed [ats_pkg::VALUE_W-1:0] req_base_value,
   input  logic signed [ats_pkg::VALUE_W-1:0] req_scale,
   input  logic                              req_has_adjust,
   input  logic signed [ats_pkg::VALUE_W-1:0] req_adjust,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ats_pkg::VALUE_W-1:0] rsp_position,
   output logic                              rsp_saturated
);

   localparam int AW = $clog2(TRACK_WORDS);
   localparam logic [19:0] TW20   = 20'(TRACK_WORDS);
   localparam logic [AW:0] TW_CNT = (AW+1)'(TRACK_WORDS);

   logic [ats_pkg::WORD_W-1:0] mem [TRACK_WORDS];
   logic [ats_pkg::WORD_W-1:0] rd_ff;
   logic [AW-1:0]              rd_addr;

   logic [AW-1:0]         p_ff, p_in;
   logic [FRAME_BITS-1:0] k_ff, k_in;
   logic [7:0]            valid_ff, valid_in;
   logic [7:0]            total_ff, total_in;
   logic [AW:0]           steps_ff, steps_in;
   logic [AW-1:0]         addr_a_ff, addr_a_in;
   logic [AW-1:0]         addr_b_ff, addr_b_in;
   logic                  two_ff, two_in;
   logic [15:0]           a_ff, a_in;
   logic [15:0]           b_ff, b_in;
   logic [ats_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic signed [31:0]    base_ff, base_in;
   logic signed [31:0]    scale_ff, scale_in;
   logic signed [31:0]    adj_ff, adj_in;
   logic                  track_ff, track_in;
   logic signed [51:0]    prod_ff, prod_in;
   logic signed [32:0]    v_ff, v_in;
   logic signed [63:0]    acc_ff, acc_in;
   logic signed [49:0]    sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_position_ff, rsp_position_in;
   logic                  rsp_saturated_ff, rsp_saturated_in;

   logic                  accept;
   logic                  load_now;
   logic                  sample_now;
   logic [AW-1:0]         load_addr_w;
   logic [15:0]           frame_ext;
   logic [16:0]           kx;
   logic [16:0]           tx;
   logic [16:0]           vx;
   logic                  gt;
   logic [8:0]            off_a;
   logic [8:0]            off_b;
   logic signed [16:0]    diff;
   logic signed [33:0]    mul_a;
   logic signed [17:0]    mul_b;
   logic signed [51:0]    mul_p;
   logic signed [49:0]    scaled;
   logic                  in_range;
   logic                  out_free;

   assign accept      = req_valid & ctrl.idle;
   assign load_now    = accept & (req_func == ats_pkg::FUNC_LOAD);
   assign sample_now  = accept & (req_func == ats_pkg::FUNC_SAMPLE);
   assign load_addr_w = AW'(ats_pkg::wrap_addr(20'(req_load_addr), TW20));
   assign frame_ext   = 16'(req_frame);
   assign kx          = 17'(k_ff);
   assign tx          = 17'(total_ff);
   assign vx          = 17'(valid_ff);
   assign out_free    = ~rsp_valid_ff | ~rsp_stall;

   assign stat.start      = sample_now;
   assign stat.with_track = req_has_track;
   assign stat.walk       = (tx <= kx) && (steps_ff < TW_CNT);
   assign stat.out_free   = out_free;

   // Track memory: one write port for loads, one registered read port.
   always_comb begin
      case (ctrl.op)
         ats_pkg::OP_RD_A: rd_addr = addr_a_ff;
         ats_pkg::OP_RD_B: rd_addr = addr_b_ff;
         default:          rd_addr = p_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_now) begin
         mem[load_addr_w] <= req_load_word;
      end
      rd_ff <= mem[rd_addr];
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      gt    = vx > kx;
      off_a = gt ? 9'(kx + 17'd1) : 9'(vx);
      off_b = gt ? 9'(kx + 17'd2) : 9'(vx + 17'd2);
      diff  = $signed({b_ff[15], b_ff}) - $signed({a_ff[15], a_ff});
      scaled = track_ff ? 50'($signed(acc_ff[63:16])) : '0;
      in_range = (sum_ff[49:31] == {19{sum_ff[49]}});

      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         ats_pkg::OP_MUL_F: begin
            mul_a = two_ff ? 34'(diff) : '0;
            mul_b = $signed({2'b00, frac_ff});
         end
         ats_pkg::OP_MUL_LO: begin
            mul_a = 34'(v_ff);
            mul_b = $signed({2'b00, scale_ff[15:0]});
         end
         ats_pkg::OP_MUL_HI: begin
            mul_a = 34'(v_ff);
            mul_b = 18'($signed(scale_ff[31:16]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      p_in      = p_ff;
      k_in      = k_ff;
      valid_in  = valid_ff;
      total_in  = total_ff;
      steps_in  = steps_ff;
      addr_a_in = addr_a_ff;
      addr_b_in = addr_b_ff;
      two_in    = two_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      frac_in   = frac_ff;
      base_in   = base_ff;
      scale_in  = scale_ff;
      adj_in    = adj_ff;
      track_in  = track_ff;
      prod_in   = prod_ff;
      v_in      = v_ff;
      acc_in    = acc_ff;
      sum_in    = sum_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_saturated_in = rsp_saturated_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;

      case (ctrl.op)
         ats_pkg::OP_IDLE: begin
            if (sample_now) begin
               p_in     = AW'(ats_pkg::wrap_addr(20'(req_track_start), TW20));
               k_in     = frame_ext[FRAME_BITS-1:0];
               steps_in = '0;
               frac_in  = req_frac;
               base_in  = req_base_value;
               scale_in = req_scale;
               adj_in   = req_has_adjust ? req_adjust : '0;
               track_in = req_has_track;
            end
         end
         ats_pkg::OP_HDR: begin
            valid_in = rd_ff[7:0];
            total_in = rd_ff[15:8];
            // A span whose total is below its valid count restarts the offset.
            if (rd_ff[15:8] < rd_ff[7:0]) begin
               k_in = '0;
            end
         end
         ats_pkg::OP_ADV: begin
            k_in     = k_ff - FRAME_BITS'(total_ff);
            p_in     = AW'(ats_pkg::wrap_addr(20'(p_ff) + 20'(valid_ff) + 20'd1, TW20));
            steps_in = steps_ff + 1'b1;
         end
         ats_pkg::OP_PICK: begin
            addr_a_in = AW'(ats_pkg::wrap_addr(20'(p_ff) + 20'(off_a), TW20));
            addr_b_in = AW'(ats_pkg::wrap_addr(20'(p_ff) + 20'(off_b), TW20));
            two_in    = gt ? (vx > (kx + 17'd1)) : (tx <= (kx + 17'd1));
         end
         ats_pkg::OP_RD_B: begin
            a_in = rd_ff;
         end
         ats_pkg::OP_LAT_B: begin
            b_in = rd_ff;
         end
         ats_pkg::OP_MUL_F: begin
            prod_in = mul_p;
         end
         ats_pkg::OP_MAKE_V: begin
            // a * 65536 plus (b - a) * frac is the exact interpolated value.
            v_in = $signed({a_ff[15], a_ff, 16'h0000}) + $signed(prod_ff[32:0]);
         end
         ats_pkg::OP_MUL_LO: begin
            prod_in = mul_p;
         end
         ats_pkg::OP_MUL_HI: begin
            acc_in  = 64'(prod_ff);
            prod_in = mul_p;
         end
         ats_pkg::OP_ACC_HI: begin
            acc_in = acc_ff + (64'(prod_ff) <<< 16) + 64'sd32768;
         end
         ats_pkg::OP_SUM: begin
            sum_in = 50'(base_ff) + scaled + 50'(adj_ff);
         end
         ats_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_saturated_in = ~in_range;
               if (in_range) begin
                  rsp_position_in = sum_ff[31:0];
               end else if (sum_ff[49]) begin
                  rsp_position_in = 32'sh8000_0000;
               end else begin
                  rsp_position_in = 32'sh7FFF_FFFF;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      k_ff      <= k_in;
      valid_ff  <= valid_in;
      total_ff  <= total_in;
      steps_ff  <= steps_in;
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      two_ff    <= two_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      frac_ff   <= frac_in;
      base_ff   <= base_in;
      scale_ff  <= scale_in;
      adj_ff    <= adj_in;
      track_ff  <= track_in;
      prod_ff   <= prod_in;
      v_ff      <= v_in;
      acc_ff    <= acc_in;
      sum_ff    <= sum_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_saturated_ff <= rsp_saturated_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

FILE: sv/animation_track_sampler_top.sv
// ----------------------------------------------------------------------------
// animation_track_sampler_top
// Samples one channel of a run-length compressed animation track held in an
// on-chip track memory, scaled and offset, as saturated signed Q16.16.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Carries
//   req_      in         req_valid/req_stall   track word loads and samples
//   rsp_      out        rsp_valid/rsp_stall   position and saturated flag
//
// A load item is written to the track memory when it is accepted and produces
// no result. A sample item without track data goes from idle to the sum and
// emit steps; with track data it first walks the span headers through the
// single read port of the track memory, then interpolates, scales and sums.
// Reset is synchronous; the track memory is not cleared and must be written
// before it is read. A stalled result is held while the next item is taken.
//
module animation_track_sampler_top #(
   parameter int TRACK_WORDS = ats_pkg::TRACK_WORDS_DEF,
   parameter int FRAME_BITS  = ats_pkg::FRAME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [ats_pkg::LOAD_ADDR_W-1:0]   req_load_addr,
   input  logic [ats_pkg::WORD_W-1:0]        req_load_word,
   input  logic                              req_has_track,
   input  logic [ats_pkg::LOAD_ADDR_W-1:0]   req_track_start,
   input  logic [ats_pkg::FRAME_W-1:0]       req_frame,
   input  logic [ats_pkg::FRAC_W-1:0]        req_frac,
   input  logic signed [ats_pkg::VALUE_W-1:0] req_base_value,
   input  logic signed [ats_pkg::VALUE_W-1:0] req_scale,
   input  logic                              req_has_adjust,
   input  logic signed [ats_pkg::VALUE_W-1:0] req_adjust,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ats_pkg::VALUE_W-1:0] rsp_position,
   output logic                              rsp_saturated
);

   ats_pkg::seq_ctrl_type ctrl;
   ats_pkg::dp_stat_type  stat;

   assign req_stall = ~ctrl.idle;

   ats_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   ats_datapath #(
      .TRACK_WORDS (TRACK_WORDS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_valid       (req_valid),
      .req_func        (req_func),
      .req_load_addr   (req_load_addr),
      .req_load_word   (req_load_word),
      .req_has_track   (req_has_track),
      .req_track_start (req_track_start),
      .req_frame       (req_frame),
      .req_frac        (req_frac),
      .req_base_value  (req_base_value),
      .req_scale       (req_scale),
      .req_has_adjust  (req_has_adjust),
      .req_adjust      (req_adjust),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
